// File: sv/bop_pkg.sv
// ----------------------------------------------------------------------------
// bop_pkg
// types and constants for the binomial option pricer
// ----------------------------------------------------------------------------
`default_nettype none
package bop_pkg;

  localparam logic [31:0] SAT32   = 32'hFFFF_FFFF;
  localparam logic [31:0] ONE_Q16 = 32'd65536;
  localparam logic [31:0] ONE_Q31 = 32'h8000_0000;

  typedef enum logic [2:0] {
    REG_NUM_STEPS = 3'd0,
    REG_UP_FACTOR = 3'd1,
    REG_DOWN_FACTOR = 3'd2,
    REG_UP_PROB = 3'd3,
    REG_DISCOUNT = 3'd4,
    REG_PAYOFF_KIND = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    PAY_CALL = 2'd0,
    PAY_PUT = 2'd1,
    PAY_DCALL = 2'd2,
    PAY_DPUT = 2'd3
  } payoff_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DOWN_MUL,
    ST_DOWN_WAIT,
    ST_LEAF,
    ST_UP_MUL,
    ST_UP_WAIT,
    ST_IND_RD,
    ST_IND_FETCH,
    ST_IND_MUL,
    ST_IND_WAIT,
    ST_IND_WR,
    ST_DISC_RD,
    ST_DISC_MUL,
    ST_DISC_WAIT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [31:0] spot;
    logic [31:0] strike;
  } in_item_t;

  typedef struct packed {
    logic [31:0] price;
    logic        saturated;
  } out_item_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [5:0]  shift;
  } mul_req_t;

endpackage
`default_nettype wire

// File: sv/bop_mul.sv
// ----------------------------------------------------------------------------
// bop_mul
// registered 32x32 product, shifted and saturated to 32 bits
// ----------------------------------------------------------------------------
`default_nettype none
module bop_mul
  import bop_pkg::*;
(
  input  wire logic        clk,
  input  wire mul_req_t    req,
  output logic [63:0]      prod,
  output logic [31:0]      res,
  output logic             sat
);
  logic [63:0] full;
  logic [5:0]  sh;
  logic [63:0] shifted;

  always_ff @(posedge clk) begin
    full <= 64'(req.a) * 64'(req.b);
    sh   <= req.shift;
  end

  assign shifted = full >> sh;
  assign sat     = |shifted[63:32];
  assign res     = sat ? SAT32 : shifted[31:0];
  assign prod    = full;
endmodule
`default_nettype wire

// File: sv/bop_ram.sv
// ----------------------------------------------------------------------------
// bop_ram
// node value memory, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none
module bop_ram #(
  parameter int AW = 10
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [31:0]   wdata,
  input  wire logic [AW-1:0] raddr,
  output logic [31:0]        rdata
);
  logic [31:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: sv/binomial_option_price.sv
// ----------------------------------------------------------------------------
// binomial_option_price
// crr binomial tree pricer with node values held in one memory
// ----------------------------------------------------------------------------
// channel  dir  handshake        payload
// in       in   valid / stall    spot, strike
// out      out  valid / stall    price, saturated
// cfg      in   valid / ready    index, data
// the single memory port pair and the shared multiplier set the pace of an item;
// each node update takes two reads, two products and a write.
// rst is synchronous; no clearing pass, node memory is written before read.
// in is stalled while an item is at work; the result waits in a register.
// ----------------------------------------------------------------------------
`default_nettype none
module binomial_option_price
  import bop_pkg::*;
#(
  parameter int MAX_STEPS = 1023
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_stall,
  input  wire in_item_t in_data,
  output logic       out_valid,
  input  wire logic  out_stall,
  output out_item_t  out_data,
  input  wire logic  cfg_valid,
  output logic       cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  localparam int AW = $clog2(MAX_STEPS + 1);

  logic [9:0]  num_steps;
  logic [31:0] up_factor;
  logic [28:0] down_factor;
  logic [31:0] up_prob;
  logic [31:0] total_discount;
  logic [1:0]  payoff_kind;

  state_t state, state_next;
  logic [AW-1:0] n, cnt, idx, lvl;
  logic [31:0] node_price, strike, vdn;
  logic [31:0] p_eff;
  logic        ovf;
  logic [63:0] acc;
  logic [31:0] price_r;
  logic        sat_r;
  logic        out_load;

  mul_req_t    req;
  logic [63:0] m_prod;
  logic [31:0] m_res;
  logic        m_sat;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   wdata, rdata;
  logic [31:0]   payoff;
  logic [AW-1:0] n_calc;
  logic [63:0]   sum;

  bop_mul u_mul (.clk, .req, .prod(m_prod), .res(m_res), .sat(m_sat));
  bop_ram #(.AW(AW)) u_ram (.clk, .we, .waddr, .wdata, .raddr, .rdata);

  assign cfg_ready = (state == ST_IDLE);
  assign in_stall  = (state != ST_IDLE);
  assign out_load  = (state == ST_OUT) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      num_steps <= 10'd1;
      up_factor <= 32'd268435456;
      down_factor <= 29'd268435456;
      up_prob <= 32'd1073741824;
      total_discount <= ONE_Q31;
      payoff_kind <= 2'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_NUM_STEPS:   num_steps <= cfg_data[9:0];
        REG_UP_FACTOR:   up_factor <= cfg_data;
        REG_DOWN_FACTOR: down_factor <= cfg_data[28:0];
        REG_UP_PROB:     up_prob <= cfg_data;
        REG_DISCOUNT:    total_discount <= cfg_data;
        REG_PAYOFF_KIND: payoff_kind <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (num_steps == 10'd0) begin
      n_calc = AW'(1);
    end else if (32'(num_steps) > 32'(MAX_STEPS)) begin
      n_calc = AW'(MAX_STEPS);
    end else begin
      n_calc = AW'(num_steps);
    end
  end

  assign p_eff = (up_prob > ONE_Q31) ? ONE_Q31 : up_prob;

  always_comb begin
    unique case (payoff_t'(payoff_kind))
      PAY_CALL:  payoff = (node_price > strike) ? node_price - strike : 32'd0;
      PAY_PUT:   payoff = (strike > node_price) ? strike - node_price : 32'd0;
      PAY_DCALL: payoff = (node_price > strike) ? ONE_Q16 : 32'd0;
      default:   payoff = (node_price < strike) ? ONE_Q16 : 32'd0;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:      if (in_valid && !in_stall) state_next = ST_DOWN_MUL;
      ST_DOWN_MUL:  state_next = ST_DOWN_WAIT;
      ST_DOWN_WAIT: state_next = (cnt == AW'(1)) ? ST_LEAF : ST_DOWN_MUL;
      ST_LEAF:      state_next = (idx == n) ? ST_IND_RD : ST_UP_MUL;
      ST_UP_MUL:    state_next = ST_UP_WAIT;
      ST_UP_WAIT:   state_next = (cnt == AW'(1)) ? ST_LEAF : ST_UP_MUL;
      ST_IND_RD:    state_next = ST_IND_FETCH;
      ST_IND_FETCH: state_next = ST_IND_MUL;
      ST_IND_MUL:   state_next = ST_IND_WAIT;
      ST_IND_WAIT:  state_next = ST_IND_WR;
      ST_IND_WR: begin
        if (idx + AW'(1) < lvl) state_next = ST_IND_RD;
        else if (lvl == AW'(1)) state_next = ST_DISC_RD;
        else state_next = ST_IND_RD;
      end
      ST_DISC_RD:   state_next = ST_DISC_MUL;
      ST_DISC_MUL:  state_next = ST_DISC_WAIT;
      ST_DISC_WAIT: state_next = ST_OUT;
      ST_OUT:       if (out_load) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // vdn is read first, vup is read in the cycle after it
  always_comb begin
    req = '0;
    we = 1'b0;
    waddr = idx;
    wdata = payoff;
    raddr = idx;
    unique case (state)
      ST_DOWN_MUL: req = '{a: node_price, b: {3'd0, down_factor}, shift: 6'd28};
      ST_UP_MUL:   req = '{a: node_price, b: up_factor, shift: 6'd28};
      ST_LEAF:     we = 1'b1;
      ST_IND_FETCH: raddr = idx + AW'(1);
      ST_IND_MUL:  req = '{a: p_eff, b: rdata, shift: 6'd0};
      ST_IND_WAIT: req = '{a: ONE_Q31 - p_eff, b: vdn, shift: 6'd0};
      ST_IND_WR: begin
        we = 1'b1;
        wdata = sum[62:31];
      end
      ST_DISC_RD:  raddr = '0;
      ST_DISC_MUL: req = '{a: rdata, b: total_discount, shift: 6'd31};
      default: ;
    endcase
  end

  assign sum = acc + m_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) out_data <= '{price: price_r, saturated: sat_r};
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        node_price <= in_data.spot;
        strike <= in_data.strike;
        n <= n_calc;
        cnt <= n_calc;
        lvl <= n_calc;
        idx <= '0;
        ovf <= 1'b0;
      end
      ST_DOWN_WAIT, ST_UP_WAIT: begin
        node_price <= m_res;
        ovf <= ovf | m_sat;
        cnt <= (cnt == AW'(1)) ? AW'(2) : cnt - AW'(1);
      end
      ST_LEAF: begin
        idx <= (idx == n) ? '0 : idx + AW'(1);
        cnt <= AW'(2);
      end
      ST_IND_FETCH: begin
        vdn <= rdata;
      end
      ST_IND_WAIT: begin
        acc <= m_prod;
      end
      ST_IND_WR: begin
        if (idx + AW'(1) < lvl) begin
          idx <= idx + AW'(1);
        end else begin
          idx <= '0;
          lvl <= lvl - AW'(1);
        end
      end
      ST_DISC_WAIT: begin
        price_r <= m_res;
        sat_r <= ovf | m_sat;
      end
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data));
  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> in_stall && !cfg_ready);
  a_node_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_IND_WR |-> idx < lvl);
`endif

endmodule
`default_nettype wire
